FILE: hdl/dobm_pkg.sv
// Package for the domino overlap matcher: sizes, FSM states and the overlap test.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dobm_pkg;
    localparam int MAX_PER_SIDE = 256;
    localparam int COORD_BITS   = 12;
    localparam int IDX_BITS     = $clog2(MAX_PER_SIDE);
    localparam int CNT_BITS     = IDX_BITS + 1;
    localparam int COORD_W      = 2 * COORD_BITS;
    localparam int OVL_DEPTH    = MAX_PER_SIDE * MAX_PER_SIDE;
    localparam int OVL_ABITS    = 2 * IDX_BITS;
    localparam int OWN_W        = IDX_BITS + 1;
    // frame: vertex, next_col, chosen column
    localparam int FRAME_W      = IDX_BITS + CNT_BITS + IDX_BITS;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_BUILD_RD,
        ST_BUILD_WR,
        ST_NEXT_ROW,
        ST_SCAN,
        ST_SCAN_CHECK,
        ST_POP,
        ST_POP_WAIT,
        ST_FLIP_RD,
        ST_FLIP_WR,
        ST_OUT
    } state_t;

    function automatic logic overlap(input logic [COORD_W-1:0] h, input logic [COORD_W-1:0] v);
        logic [COORD_BITS:0] hx, hy, vx, vy;
        hx = {1'b0, h[COORD_BITS-1:0]};
        hy = {1'b0, h[COORD_W-1:COORD_BITS]};
        vx = {1'b0, v[COORD_BITS-1:0]};
        vy = {1'b0, v[COORD_W-1:COORD_BITS]};
        return ((hx == vx) || (hx + 1'b1 == vx)) && ((hy == vy) || (hy == vy + 1'b1));
    endfunction
endpackage
`default_nettype wire

FILE: hdl/dobm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/domino_overlap_bipartite_matching.sv
// Top level of the domino overlap matcher: load, overlap build, augmenting search.
// Depends on dobm_pkg and dobm_ram.
// Loading takes one transfer per cycle. After a last item the overlap matrix is built
// (a read and write per H/V pair, one read if a side is empty), then each row runs
// the stack-based search: a start state, a scan and check per tested column, a scan,
// a pop and, above the bottom, a wait per exhausted frame, a write per flipped frame,
// with stack reads between. The result waits for m_tready, then a clear pass precedes
// input. Reset: control and counts clear asynchronously, then the same pass runs.
`timescale 1ns / 1ps
`default_nettype none
module domino_overlap_bipartite_matching (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // is_vertical, x_pos[11:0], y_pos[11:0], zero pad
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // max_kept[9:0], matching_size[8:0], overflow, pad
);
    import dobm_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_BITS-1:0] hcnt_reg, vcnt_reg;
    logic ovf_reg;
    logic [IDX_BITS-1:0] i_reg;       // horizontal index / augment start
    logic [CNT_BITS-1:0] j_reg;       // build column, flip frame, clear address
    logic [CNT_BITS-1:0] sp_reg;
    logic [IDX_BITS-1:0] vtx_reg;     // top frame vertex
    logic [CNT_BITS-1:0] nc_reg;      // top frame next_col
    logic [IDX_BITS-1:0] col_reg;     // candidate column
    logic [CNT_BITS-1:0] matched_reg;
    logic [9:0] kept;

    wire logic acc = s_tvalid && s_tready;
    wire logic in_v = s_tdata[0];
    wire logic [COORD_W-1:0] in_xy = {s_tdata[24:13], s_tdata[12:1]};

    logic h_we, v_we;
    logic [COORD_W-1:0] h_rd, v_rd;
    logic ovl_we, ovl_rd;
    logic [OVL_ABITS-1:0] ovl_wa, ovl_ra;
    logic vis_we;
    logic [IDX_BITS-1:0] vis_wa;
    logic [CNT_BITS-1:0] vis_wd, vis_rd;
    logic own_we;
    logic [IDX_BITS-1:0] own_wa;
    logic [OWN_W-1:0] own_wd, own_rd;
    logic stk_we;
    logic [IDX_BITS-1:0] stk_wa, stk_ra;
    logic [FRAME_W-1:0] stk_wd, stk_rd;

    logic [CNT_BITS-1:0] mark, sp_m1, sp_m2, j_m1, nc_p1, stk_nc;
    logic [IDX_BITS-1:0] stk_vtx, stk_col;
    logic cand, top, row_last, col_more;

    // visited marks hold start row + 1, so a search sees only its own marks
    assign mark     = {1'b0, i_reg} + CNT_BITS'(1);
    assign sp_m1    = sp_reg - CNT_BITS'(1);
    assign sp_m2    = sp_reg - CNT_BITS'(2);
    assign j_m1     = j_reg - CNT_BITS'(1);
    assign nc_p1    = nc_reg + CNT_BITS'(1);
    assign stk_vtx  = stk_rd[FRAME_W-1 -: IDX_BITS];
    assign stk_nc   = stk_rd[IDX_BITS +: CNT_BITS];
    assign stk_col  = stk_rd[IDX_BITS-1:0];
    assign cand     = (vis_rd != mark) && ovl_rd;
    assign top      = (j_reg == sp_reg);
    assign row_last = ({1'b0, i_reg} + CNT_BITS'(1)) >= hcnt_reg;
    assign col_more = (j_reg + CNT_BITS'(1)) < vcnt_reg;
    assign kept     = {1'b0, hcnt_reg} + {1'b0, vcnt_reg} - {1'b0, matched_reg};

    // coordinate memories
    dobm_ram #(.WIDTH(COORD_W), .DEPTH(MAX_PER_SIDE)) u_h (
        .clk, .we(h_we), .waddr(hcnt_reg[IDX_BITS-1:0]), .wdata(in_xy),
        .raddr(i_reg), .rdata(h_rd));
    dobm_ram #(.WIDTH(COORD_W), .DEPTH(MAX_PER_SIDE)) u_v (
        .clk, .we(v_we), .waddr(vcnt_reg[IDX_BITS-1:0]), .wdata(in_xy),
        .raddr(j_reg[IDX_BITS-1:0]), .rdata(v_rd));

    // overlap matrix memory
    dobm_ram #(.WIDTH(1), .DEPTH(OVL_DEPTH)) u_ovl (
        .clk, .we(ovl_we), .waddr(ovl_wa), .wdata(overlap(h_rd, v_rd)),
        .raddr(ovl_ra), .rdata(ovl_rd));

    // visited marks and column owners {valid, vertex}
    dobm_ram #(.WIDTH(CNT_BITS), .DEPTH(MAX_PER_SIDE)) u_vis (
        .clk, .we(vis_we), .waddr(vis_wa), .wdata(vis_wd),
        .raddr(nc_reg[IDX_BITS-1:0]), .rdata(vis_rd));
    dobm_ram #(.WIDTH(OWN_W), .DEPTH(MAX_PER_SIDE)) u_own (
        .clk, .we(own_we), .waddr(own_wa), .wdata(own_wd),
        .raddr(nc_reg[IDX_BITS-1:0]), .rdata(own_rd));

    // stack of frames below the top one
    dobm_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_PER_SIDE)) u_stk (
        .clk, .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {4'b0, ovf_reg, matched_reg, kept};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (j_reg == CNT_BITS'(MAX_PER_SIDE - 1))
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (acc && s_tlast)
                    state_next = ST_BUILD_RD;
            end
            ST_BUILD_RD:
            begin
                if (hcnt_reg == '0 || vcnt_reg == '0)
                    state_next = ST_NEXT_ROW;
                else
                    state_next = ST_BUILD_WR;
            end
            ST_BUILD_WR:
            begin
                if (col_more || !row_last)
                    state_next = ST_BUILD_RD;
                else
                    state_next = ST_NEXT_ROW;
            end
            ST_NEXT_ROW:
            begin
                if ({1'b0, i_reg} < hcnt_reg)
                    state_next = ST_SCAN;
                else
                    state_next = ST_OUT;
            end
            ST_SCAN:
            begin
                if (nc_reg >= vcnt_reg)
                    state_next = ST_POP;
                else
                    state_next = ST_SCAN_CHECK;
            end
            ST_SCAN_CHECK:
            begin
                if (cand && !own_rd[IDX_BITS])
                    state_next = ST_FLIP_WR;
                else
                    state_next = ST_SCAN;
            end
            ST_POP:
            begin
                if (sp_reg == CNT_BITS'(1))
                    state_next = row_last ? ST_OUT : ST_NEXT_ROW;
                else
                    state_next = ST_POP_WAIT;
            end
            ST_POP_WAIT:   state_next = ST_SCAN;
            ST_FLIP_WR:
            begin
                if (j_reg == CNT_BITS'(1))
                    state_next = row_last ? ST_OUT : ST_NEXT_ROW;
                else
                    state_next = ST_FLIP_RD;
            end
            ST_FLIP_RD:    state_next = ST_FLIP_WR;
            ST_OUT:
            begin
                if (m_tready)
                    state_next = ST_CLEAR;
            end
            default:       state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        h_we   = acc && !in_v && (hcnt_reg < CNT_BITS'(MAX_PER_SIDE));
        v_we   = acc && in_v && (vcnt_reg < CNT_BITS'(MAX_PER_SIDE));
        ovl_we = (state_reg == ST_BUILD_WR);
        ovl_wa = {i_reg, j_reg[IDX_BITS-1:0]};
        ovl_ra = {vtx_reg, nc_reg[IDX_BITS-1:0]};
        vis_we = (state_reg == ST_CLEAR) || ((state_reg == ST_SCAN_CHECK) && cand);
        vis_wa = (state_reg == ST_CLEAR) ? j_reg[IDX_BITS-1:0] : col_reg;
        vis_wd = (state_reg == ST_CLEAR) ? '0 : mark;
        own_we = (state_reg == ST_CLEAR) || (state_reg == ST_FLIP_WR);
        if (state_reg == ST_CLEAR)
        begin
            own_wa = j_reg[IDX_BITS-1:0];
            own_wd = '0;
        end
        else
        begin
            // top frame lives in registers, lower frames come from the stack
            own_wa = top ? col_reg : stk_col;
            own_wd = {1'b1, top ? vtx_reg : stk_vtx};
        end
        stk_we = (state_reg == ST_SCAN_CHECK) && cand && own_rd[IDX_BITS];
        stk_wa = sp_m1[IDX_BITS-1:0];
        stk_wd = {vtx_reg, nc_p1, col_reg};
        stk_ra = (state_reg == ST_FLIP_RD) ? j_m1[IDX_BITS-1:0] : sp_m2[IDX_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            hcnt_reg    <= '0;
            vcnt_reg    <= '0;
            ovf_reg     <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            sp_reg      <= '0;
            vtx_reg     <= '0;
            nc_reg      <= '0;
            col_reg     <= '0;
            matched_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_CLEAR:
                begin
                    j_reg <= j_reg + CNT_BITS'(1);
                end
                ST_LOAD:
                begin
                    if (acc)
                    begin
                        if (in_v)
                        begin
                            if (vcnt_reg < CNT_BITS'(MAX_PER_SIDE))
                                vcnt_reg <= vcnt_reg + CNT_BITS'(1);
                            else
                                ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            if (hcnt_reg < CNT_BITS'(MAX_PER_SIDE))
                                hcnt_reg <= hcnt_reg + CNT_BITS'(1);
                            else
                                ovf_reg <= 1'b1;
                        end
                        if (s_tlast)
                        begin
                            i_reg       <= '0;
                            j_reg       <= '0;
                            matched_reg <= '0;
                        end
                    end
                end
                ST_BUILD_WR:
                begin
                    if (col_more)
                    begin
                        j_reg <= j_reg + CNT_BITS'(1);
                    end
                    else if (!row_last)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + IDX_BITS'(1);
                    end
                    else
                    begin
                        i_reg <= '0;
                    end
                end
                ST_NEXT_ROW:
                begin
                    vtx_reg <= i_reg;
                    nc_reg  <= '0;
                    sp_reg  <= CNT_BITS'(1);
                end
                ST_SCAN:
                begin
                    col_reg <= nc_reg[IDX_BITS-1:0];
                end
                ST_SCAN_CHECK:
                begin
                    if (cand && own_rd[IDX_BITS])
                    begin
                        // descend into the owner; current frame pushed with next_col advanced
                        sp_reg  <= sp_reg + CNT_BITS'(1);
                        vtx_reg <= own_rd[IDX_BITS-1:0];
                        nc_reg  <= '0;
                    end
                    else
                    begin
                        nc_reg <= nc_p1;
                        if (cand)
                            j_reg <= sp_reg;
                    end
                end
                ST_POP:
                begin
                    if (sp_reg == CNT_BITS'(1))
                        i_reg <= i_reg + IDX_BITS'(1);
                end
                ST_POP_WAIT:
                begin
                    sp_reg  <= sp_m1;
                    vtx_reg <= stk_vtx;
                    nc_reg  <= stk_nc;
                end
                ST_FLIP_WR:
                begin
                    if (j_reg == CNT_BITS'(1))
                    begin
                        matched_reg <= matched_reg + CNT_BITS'(1);
                        i_reg       <= i_reg + IDX_BITS'(1);
                    end
                    else
                    begin
                        j_reg <= j_m1;
                    end
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        hcnt_reg <= '0;
                        vcnt_reg <= '0;
                        ovf_reg  <= 1'b0;
                        j_reg    <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for domino_overlap_bipartite_matching: stream driver,
// result monitor and a max-matching predictor that checks max_kept, matching_size, overflow.
// Depends on dobm_pkg and the RTL top level.
`timescale 1ns / 1ps
module tb;
    import dobm_pkg::*;

    localparam int COORD_TOP = 4094;

    typedef struct packed {
        logic             vert;
        logic [11:0]      x;
        logic [11:0]      y;
        logic             last;
    } domino_t;

    typedef struct packed {
        logic [9:0]       kept;
        logic [8:0]       msize;
        logic             ovf;
    } tally_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    domino_t pending_dominoes[$];
    tally_t  expected_tallies[$];
    int      errors = 0;

    // predictor copy of the case being loaded
    logic [11:0] hx_mem[MAX_PER_SIDE], hy_mem[MAX_PER_SIDE];
    logic [11:0] vx_mem[MAX_PER_SIDE], vy_mem[MAX_PER_SIDE];
    int          n_horiz = 0, n_vert = 0;
    logic        dropped = 1'b0;

    domino_overlap_bipartite_matching u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // no wrap on the +1: compare in 13 bits
    function automatic bit dominoes_touch(int i, int j);
        logic [12:0] ax, ay, bx, by;
        ax = {1'b0, hx_mem[i]};
        ay = {1'b0, hy_mem[i]};
        bx = {1'b0, vx_mem[j]};
        by = {1'b0, vy_mem[j]};
        return ((ax == bx) || (ax + 13'd1 == bx)) && ((ay == by) || (ay == by + 13'd1));
    endfunction

    // BFS augmenting paths; any maximum matching gives the same size
    function automatic int max_matching();
        bit adj[MAX_PER_SIDE][MAX_PER_SIDE];
        int col_owner[MAX_PER_SIDE];
        int row_match[MAX_PER_SIDE];
        int from_row[MAX_PER_SIDE];
        bit seen[MAX_PER_SIDE];
        int bfs[$];
        int total, u, a, j, hit, prev;
        total = 0;
        for (int i = 0; i < n_horiz; i++)
            for (int k = 0; k < n_vert; k++)
                adj[i][k] = dominoes_touch(i, k);
        for (int k = 0; k < MAX_PER_SIDE; k++)
        begin
            col_owner[k] = -1;
            row_match[k] = -1;
        end
        for (u = 0; u < n_horiz; u++)
        begin
            for (int k = 0; k < MAX_PER_SIDE; k++)
                seen[k] = 1'b0;
            bfs = {u};
            hit = -1;
            while (bfs.size() > 0 && hit < 0)
            begin
                a = bfs.pop_front();
                for (j = 0; j < n_vert && hit < 0; j++)
                begin
                    if (adj[a][j] && !seen[j])
                    begin
                        seen[j] = 1'b1;
                        from_row[j] = a;
                        if (col_owner[j] < 0)
                            hit = j;
                        else
                            bfs.push_back(col_owner[j]);
                    end
                end
            end
            if (hit >= 0)
            begin
                total++;
                j = hit;
                forever
                begin
                    a = from_row[j];
                    prev = row_match[a];
                    col_owner[j] = a;
                    row_match[a] = j;
                    if (a == u)
                        break;
                    j = prev;
                end
            end
        end
        return total;
    endfunction

    task automatic absorb_domino(domino_t d);
        tally_t t;
        int m;
        if (d.vert)
        begin
            if (n_vert < MAX_PER_SIDE)
            begin
                vx_mem[n_vert] = d.x;
                vy_mem[n_vert] = d.y;
                n_vert++;
            end
            else
                dropped = 1'b1;
        end
        else
        begin
            if (n_horiz < MAX_PER_SIDE)
            begin
                hx_mem[n_horiz] = d.x;
                hy_mem[n_horiz] = d.y;
                n_horiz++;
            end
            else
                dropped = 1'b1;
        end
        if (d.last)
        begin
            m = max_matching();
            t.kept = 10'(n_horiz + n_vert - m);
            t.msize = 9'(m);
            t.ovf = dropped;
            expected_tallies.push_back(t);
            n_horiz = 0;
            n_vert = 0;
            dropped = 1'b0;
        end
    endtask

    // driver: bursts and gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        domino_t d, nxt;
        logic    go;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                d.vert = s_tdata[0];
                d.x = s_tdata[12:1];
                d.y = s_tdata[24:13];
                d.last = s_tlast;
                absorb_domino(d);
            end
            if (!s_tvalid || s_tready)
            begin
                go = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_dominoes.size() > 0)
                begin
                    nxt = pending_dominoes.pop_front();
                    go = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 3) == 0 ? 1000 : $urandom_range(1, 12);
                        gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
                    end
                end
                s_tvalid <= go;
                if (go)
                begin
                    s_tdata <= {7'd0, nxt.y, nxt.x, nxt.vert};
                    s_tlast <= nxt.last;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    int stall_mode = 0, mode_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        tally_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_tallies.size() == 0)
                begin
                    $error("unexpected result transfer %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_tallies.pop_front();
                    if (m_tdata[9:0] !== want.kept)
                    begin
                        $error("max_kept exp %0d got %0d", want.kept, m_tdata[9:0]);
                        errors++;
                    end
                    if (m_tdata[18:10] !== want.msize)
                    begin
                        $error("matching_size exp %0d got %0d", want.msize, m_tdata[18:10]);
                        errors++;
                    end
                    if (m_tdata[19] !== want.ovf)
                    begin
                        $error("overflow exp %0d got %0d", want.ovf, m_tdata[19]);
                        errors++;
                    end
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 3000);
            end
            else
                mode_left--;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (mode_left % 37) > 30;
            endcase
        end
    end

    function automatic domino_t mk(bit v, int x, int y, bit l);
        domino_t d;
        d.vert = v;
        d.x = 12'(x);
        d.y = 12'(y);
        d.last = l;
        return d;
    endfunction

    // random case clustered in a small window so dominoes overlap often
    task automatic add_random_case(int count);
        int bx, by, span;
        bx = $urandom_range(0, 5) == 0 ? COORD_TOP - 6 : $urandom_range(0, COORD_TOP - 6);
        by = $urandom_range(0, 5) == 0 ? COORD_TOP - 6 : $urandom_range(0, COORD_TOP - 6);
        if ($urandom_range(0, 4) == 0)
        begin
            bx = $urandom_range(0, 1) ? 0 : bx;
            by = $urandom_range(0, 1) ? 0 : by;
        end
        span = $urandom_range(1, 6);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                pending_dominoes.push_back(mk($urandom_range(0, 1), $urandom_range(0, COORD_TOP),
                                             $urandom_range(0, COORD_TOP), i == count - 1));
            else
                pending_dominoes.push_back(mk($urandom_range(0, 1), bx + $urandom_range(0, span),
                                             by + $urandom_range(0, span), i == count - 1));
        end
    endtask

    initial
    begin
        int fed;
        // directed: single dominoes, corners, no wrap at the top coordinate
        pending_dominoes.push_back(mk(0, 0, 0, 1));
        pending_dominoes.push_back(mk(1, COORD_TOP, COORD_TOP, 1));
        pending_dominoes.push_back(mk(0, 0, 0, 0));
        pending_dominoes.push_back(mk(1, 1, 0, 1));
        pending_dominoes.push_back(mk(0, 5, 7, 0));
        pending_dominoes.push_back(mk(1, 5, 6, 1));
        pending_dominoes.push_back(mk(0, COORD_TOP, COORD_TOP, 0));
        pending_dominoes.push_back(mk(1, 0, COORD_TOP, 0));
        pending_dominoes.push_back(mk(1, COORD_TOP, 0, 0));
        pending_dominoes.push_back(mk(1, COORD_TOP, COORD_TOP - 1, 1));
        pending_dominoes.push_back(mk(0, 2, 2, 0));
        pending_dominoes.push_back(mk(0, 2, 3, 0));
        pending_dominoes.push_back(mk(1, 2, 2, 0));
        pending_dominoes.push_back(mk(1, 3, 2, 0));
        pending_dominoes.push_back(mk(1, 2, 2, 1));
        pending_dominoes.push_back(mk(1, 4000, 100, 0));
        pending_dominoes.push_back(mk(1, 4001, 100, 1));
        // capacity: both sides overfilled, dropped domino on the last item
        for (int i = 0; i < MAX_PER_SIDE + 1; i++)
            pending_dominoes.push_back(mk(0, 2 * i, 20, 0));
        for (int i = 0; i < MAX_PER_SIDE + 1; i++)
            pending_dominoes.push_back(mk(1, 2 * i, 300, i == MAX_PER_SIDE));
        pending_dominoes.push_back(mk(1, 9, 9, 1));
        fed = 0;
        while (fed < 1200)
        begin
            int n;
            n = $urandom_range(0, 9) == 0 ? $urandom_range(25, 60) : $urandom_range(1, 24);
            add_random_case(n);
            fed += n;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_dominoes.size() == 0 && !s_tvalid && expected_tallies.size() == 0);
        repeat (400) @(posedge clk);
        if (errors == 0 && expected_tallies.size() == 0)
            $display("PASS domino_overlap_bipartite_matching");
        else
            $display("FAIL domino_overlap_bipartite_matching");
        $finish;
    end

    initial
    begin
        #(64'd80_000_000);
        $display("FAIL domino_overlap_bipartite_matching");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/dobm_pkg.sv
hdl/dobm_ram.sv
hdl/domino_overlap_bipartite_matching.sv
tb/tb.sv
